[rtl/bdd_pkg.sv]
// Shared widths, status codes and register map of the binary to BCD converter.
package bdd_pkg;

	localparam int VALUE_W     = 32;
	localparam int DIGIT_W     = 4;
	localparam int DIGIT_SLOTS = 10;
	localparam int DIGITS_W    = DIGIT_SLOTS * DIGIT_W;
	localparam int STATUS_W    = 2;
	localparam int COUNT_W     = 4;
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;

	typedef logic [STATUS_W-1:0] status_t;

	localparam status_t STATUS_OK        = 2'd0;
	localparam status_t STATUS_BAD_COUNT = 2'd1;
	localparam status_t STATUS_OVERFLOW  = 2'd2;

	// Register index, taken from the word address bit of paddr.
	localparam logic REG_DIGIT_COUNT = 1'b0;

	localparam logic [COUNT_W-1:0] DIGIT_COUNT_RESET = 4'd10;

endpackage

[rtl/bdd_in_if.sv]
// Input channel: one binary value per word.
interface bdd_in_if;
	logic                        valid;
	logic                        ready;
	logic [bdd_pkg::VALUE_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

[rtl/bdd_out_if.sv]
// Output channel: packed BCD digits and status per word.
interface bdd_out_if;
	logic                         valid;
	logic                         ready;
	logic [bdd_pkg::DIGITS_W-1:0] bcd_digits;
	bdd_pkg::status_t             status;

	modport source (output valid, output bcd_digits, output status, input ready);
	modport sink   (input valid, input bcd_digits, input status, output ready);
endinterface

[rtl/binary_to_bcd_digits_core.sv]
// Binary to BCD converter top level: register port, cell chain and output register.
// Path: an accepted word passes through the 32 cells in turn and then the output register.
// Throughput: one word per cycle while rsp.ready does not stall; each cell handles one binary bit of one word.
// Stalls: a cell advances when the next one is empty or moving, so bubbles close up.
// Reset: arst_n clears every valid bit and sets digit_count to ten; payload is not reset.
module binary_to_bcd_digits_core #(
	parameter int MAX_DIGITS = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bdd_pkg::PADDR_W-1:0]   paddr,
	input  logic [bdd_pkg::PDATA_W-1:0]   pwdata,
	output logic [bdd_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	bdd_in_if.sink                        req,
	bdd_out_if.source                     rsp
);

	localparam int NUM_CELLS = bdd_pkg::VALUE_W;
	localparam int BCD_W     = MAX_DIGITS * bdd_pkg::DIGIT_W;
	localparam logic [bdd_pkg::COUNT_W-1:0] MAX_COUNT = bdd_pkg::COUNT_W'(MAX_DIGITS);

	// ---------------------------------------------------------------
	// Register port: one register, selected by the word address bit.
	// ---------------------------------------------------------------
	logic [bdd_pkg::COUNT_W-1:0] digit_count_q;
	logic                        reg_sel;

	assign reg_sel = paddr[2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_count_q <= bdd_pkg::DIGIT_COUNT_RESET;
		end else if (psel && penable && pwrite && reg_sel == bdd_pkg::REG_DIGIT_COUNT) begin
			digit_count_q <= pwdata[bdd_pkg::COUNT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_sel == bdd_pkg::REG_DIGIT_COUNT) begin
			prdata[bdd_pkg::COUNT_W-1:0] = digit_count_q;
		end
	end

	// ---------------------------------------------------------------
	// Cell chain: link k feeds cell k. Link 0 is the input word with
	// cleared digits; link NUM_CELLS holds the finished digits.
	// ---------------------------------------------------------------
	logic                          vld [0:NUM_CELLS];
	logic                          rdy [0:NUM_CELLS];
	logic [BCD_W-1:0]              bcd [0:NUM_CELLS];
	logic [bdd_pkg::VALUE_W-1:0]   bin [0:NUM_CELLS];
	logic                          ovf [0:NUM_CELLS];

	assign vld[0]    = req.valid;
	assign req.ready = rdy[0];
	assign bcd[0]    = '0;
	assign bin[0]    = req.value;
	assign ovf[0]    = 1'b0;

	for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
		bdd_cell #(
			.NUM_DIGITS(MAX_DIGITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (vld[c]),
			.up_ready (rdy[c]),
			.up_bcd   (bcd[c]),
			.up_bin   (bin[c]),
			.up_ovf   (ovf[c]),
			.dn_valid (vld[c+1]),
			.dn_ready (rdy[c+1]),
			.dn_bcd   (bcd[c+1]),
			.dn_bin   (bin[c+1]),
			.dn_ovf   (ovf[c+1])
		);
	end

	// ---------------------------------------------------------------
	// Finish: keep the requested low digits, flag any nonzero digit
	// above them (or a carry out of the chain) as overflow; a count above MAX_DIGITS reports a bad count.
	// ---------------------------------------------------------------
	logic [bdd_pkg::DIGITS_W-1:0]    digits_d;
	logic [bdd_pkg::DIGIT_SLOTS-1:0] high_nz;
	logic                            bad_count;
	bdd_pkg::status_t                status_d;

	for (genvar k = 0; k < bdd_pkg::DIGIT_SLOTS; k++) begin : g_digit
		if (k < MAX_DIGITS) begin : g_held
			logic [bdd_pkg::DIGIT_W-1:0] dig;
			logic                        keep;
			assign dig  = bcd[NUM_CELLS][k*bdd_pkg::DIGIT_W +: bdd_pkg::DIGIT_W];
			assign keep = bdd_pkg::COUNT_W'(k) < digit_count_q;
			assign digits_d[k*bdd_pkg::DIGIT_W +: bdd_pkg::DIGIT_W] = keep ? dig : '0;
			assign high_nz[k] = !keep && (dig != '0);
		end else begin : g_unused
			assign digits_d[k*bdd_pkg::DIGIT_W +: bdd_pkg::DIGIT_W] = '0;
			assign high_nz[k] = 1'b0;
		end
	end

	assign bad_count = digit_count_q > MAX_COUNT;

	always_comb begin
		if (bad_count) begin
			status_d = bdd_pkg::STATUS_BAD_COUNT;
		end else if (ovf[NUM_CELLS] || (high_nz != '0)) begin
			status_d = bdd_pkg::STATUS_OVERFLOW;
		end else begin
			status_d = bdd_pkg::STATUS_OK;
		end
	end

	// ---------------------------------------------------------------
	// Output register: hold the word until taken, load when free.
	// ---------------------------------------------------------------
	logic                         out_valid_q;
	logic [bdd_pkg::DIGITS_W-1:0] out_digits_q;
	bdd_pkg::status_t             out_status_q;

	assign rdy[NUM_CELLS] = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rdy[NUM_CELLS]) begin
			out_valid_q <= vld[NUM_CELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[NUM_CELLS] && vld[NUM_CELLS]) begin
			out_digits_q <= bad_count ? '0 : digits_d;
			out_status_q <= status_d;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.bcd_digits = out_digits_q;
	assign rsp.status     = out_status_q;

`ifndef ASSERT_OFF
	// An accepted word lands in the first cell on the next edge.
	a_enter_chain: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> vld[1])
		else $error("accepted word did not enter the cell chain");

	// Ten digits always hold a 32-bit value, so no carry leaves the chain.
	a_no_carry_full: assert property (@(posedge clk) disable iff (!arst_n)
		(MAX_DIGITS == bdd_pkg::DIGIT_SLOTS) && vld[NUM_CELLS] |-> !ovf[NUM_CELLS])
		else $error("carry out of a full-width digit chain");

	// A bad digit count yields all-zero digits.
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == bdd_pkg::STATUS_BAD_COUNT |-> rsp.bcd_digits == '0)
		else $error("digits not cleared on bad digit count");

	// Every binary bit has been shifted out by the end of the chain.
	a_bin_drained: assert property (@(posedge clk) disable iff (!arst_n)
		vld[NUM_CELLS] |-> bin[NUM_CELLS] == '0)
		else $error("binary bits left at end of chain");
`endif

endmodule

[rtl/bdd_cell.sv]
// One double-dabble step: adjust each digit, shift in one binary bit.
module bdd_cell #(
	parameter int NUM_DIGITS = 10
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              up_valid,
	output logic                              up_ready,
	input  logic [NUM_DIGITS*bdd_pkg::DIGIT_W-1:0] up_bcd,
	input  logic [bdd_pkg::VALUE_W-1:0]       up_bin,
	input  logic                              up_ovf,
	output logic                              dn_valid,
	input  logic                              dn_ready,
	output logic [NUM_DIGITS*bdd_pkg::DIGIT_W-1:0] dn_bcd,
	output logic [bdd_pkg::VALUE_W-1:0]       dn_bin,
	output logic                              dn_ovf
);

	localparam int BCD_W = NUM_DIGITS * bdd_pkg::DIGIT_W;

	logic [BCD_W-1:0] adj;
	logic [BCD_W:0]   shifted;
	logic             valid_q;
	logic [BCD_W-1:0] bcd_q;
	logic [bdd_pkg::VALUE_W-1:0] bin_q;
	logic             ovf_q;

	// Add three to every digit of five or more before the shift.
	always_comb begin
		for (int k = 0; k < NUM_DIGITS; k++) begin
			if (up_bcd[k*bdd_pkg::DIGIT_W +: bdd_pkg::DIGIT_W] >= 4'd5) begin
				adj[k*bdd_pkg::DIGIT_W +: bdd_pkg::DIGIT_W] =
					up_bcd[k*bdd_pkg::DIGIT_W +: bdd_pkg::DIGIT_W] + 4'd3;
			end else begin
				adj[k*bdd_pkg::DIGIT_W +: bdd_pkg::DIGIT_W] =
					up_bcd[k*bdd_pkg::DIGIT_W +: bdd_pkg::DIGIT_W];
			end
		end
		shifted = {adj, up_bin[bdd_pkg::VALUE_W-1]};
	end

	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	// Carry out of the top digit means the value needs more digits than held.
	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			bcd_q <= shifted[BCD_W-1:0];
			bin_q <= {up_bin[bdd_pkg::VALUE_W-2:0], 1'b0};
			ovf_q <= up_ovf | shifted[BCD_W];
		end
	end

	assign dn_valid = valid_q;
	assign dn_bcd   = bcd_q;
	assign dn_bin   = bin_q;
	assign dn_ovf   = ovf_q;

endmodule
